>>> hdl/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Types and constants shared by the closest-points unit and its parts.
// ----------------------------------------------------------------------------
package cpts_pkg;

  // One accepted request: both lines plus the start-point difference.
  typedef struct packed {
    logic [2:0][31:0] p0;
    logic [2:0][31:0] v0;
    logic [2:0][31:0] p1;
    logic [2:0][31:0] v1;
    logic [2:0][32:0] d;
  } item_t;

  // One finished result.
  typedef struct packed {
    logic [2:0][31:0] cp0;
    logic [2:0][31:0] cp1;
    logic [3:0]       flags;
  } res_t;

  // Clamp flag bits, same layout as clamp_mode.
  localparam logic [3:0] FLAG_LO_B = 4'h1;
  localparam logic [3:0] FLAG_LO_A = 4'h2;
  localparam logic [3:0] FLAG_HI_B = 4'h4;
  localparam logic [3:0] FLAG_HI_A = 4'h8;
  localparam logic [3:0] FLAGS_A   = 4'hA;
  localparam logic [3:0] FLAGS_ALL = 4'hF;

  // Register indexes (paddr[2]).
  localparam logic REG_CLAMP_MODE = 1'b0;
  localparam logic REG_EPSILON_SQ = 1'b1;

  localparam logic [3:0]  CLAMP_MODE_RST = 4'hF;
  localparam logic [15:0] EPSILON_SQ_RST = 16'h0001;

  // Back-end sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_A_CHK,
    ST_GOT_B,
    ST_GOT_C,
    ST_GOT_E,
    ST_GOT_F,
    ST_AC,
    ST_BB,
    ST_EA,
    ST_AF,
    ST_BE,
    ST_T1,
    ST_BT,
    ST_T0,
    ST_CP0,
    ST_G,
    ST_RC,
    ST_CP1,
    ST_PAR1,
    ST_PAR2,
    ST_DEG_END,
    ST_DONE,
    ST_DOT,
    ST_DOT_W,
    ST_PT,
    ST_PT_W,
    ST_MUL,
    ST_MUL_W,
    ST_DIV,
    ST_DIV_W,
    ST_PJ_START,
    ST_PJ_C,
    ST_PJ_DD,
    ST_PJ_T
  } state_e;

endpackage

>>> hdl/cpts_fifo.sv
// ----------------------------------------------------------------------------
// cpts_fifo
// Small register queue with full/empty flags, used on both sides of the unit.
// ----------------------------------------------------------------------------
module cpts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hdl/cpts_front.sv
// ----------------------------------------------------------------------------
// cpts_front
// Request intake: form the start-point difference and queue the request.
// ----------------------------------------------------------------------------
module cpts_front #(
  parameter int DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [2:0][31:0]      p0_i,
  input  logic [2:0][31:0]      v0_i,
  input  logic [2:0][31:0]      p1_i,
  input  logic [2:0][31:0]      v1_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output cpts_pkg::item_t       item_o
);
  import cpts_pkg::*;

  item_t                 wr_item;
  logic [$bits(item_t)-1:0] rd_bits;
  logic                  empty;

  always_comb begin
    wr_item.p0 = p0_i;
    wr_item.v0 = v0_i;
    wr_item.p1 = p1_i;
    wr_item.v1 = v1_i;
    for (int i = 0; i < 3; i++) begin
      wr_item.d[i] = 33'($signed({p0_i[i][31], p0_i[i]}) - $signed({p1_i[i][31], p1_i[i]}));
    end
  end

  cpts_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(wr_item),
    .full_o (full_o),
    .pop_i  (pop_i),
    .rdata_o(rd_bits),
    .empty_o(empty)
  );

  assign valid_o = !empty;
  assign item_o  = item_t'(rd_bits);

endmodule

>>> hdl/cpts_mul.sv
// ----------------------------------------------------------------------------
// cpts_mul
// Signed 64x64 multiplier, four 32x32 partial products accumulated in turn.
// ----------------------------------------------------------------------------
module cpts_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [63:0]   a_i,
  input  logic signed [63:0]   b_i,
  output logic                 done_o,
  output logic signed [127:0]  p_o
);
  logic         busy_q, done_q, neg_q;
  logic [1:0]   k_q;
  logic [63:0]  ux_q, uy_q;
  logic [127:0] acc_q;
  logic [31:0]  xa, yb;
  logic [63:0]  pp;
  logic [127:0] term;

  always_comb begin
    xa = k_q[1] ? ux_q[63:32] : ux_q[31:0];
    yb = k_q[0] ? uy_q[63:32] : uy_q[31:0];
    pp = xa * yb;
    unique case (k_q)
      2'd0:    term = {64'd0, pp};
      2'd3:    term = {pp, 64'd0};
      default: term = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= busy_q && (k_q == 2'd3);
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + 1'b1;
        if (k_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ux_q  <= a_i[63] ? 64'(-a_i) : a_i;
      uy_q  <= b_i[63] ? 64'(-b_i) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + term;
    end
  end

  assign done_o = done_q;
  assign p_o    = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

>>> hdl/cpts_div.sv
// ----------------------------------------------------------------------------
// cpts_div
// Signed 128/128 restoring divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module cpts_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [127:0]  num_i,
  input  logic signed [127:0]  den_i,
  output logic                 done_o,
  output logic signed [63:0]   q_o
);
  localparam logic [63:0] T_LIMIT = 64'h3FFF_FFFF_FFFF_FFFF;

  logic         busy_q, done_q, neg_q, zero_q;
  logic [6:0]   cnt_q;
  logic [127:0] n_q, d_q, r_q, q_q;
  logic [128:0] r2, diff;
  logic         ge;
  logic [63:0]  mag;

  always_comb begin
    r2   = {r_q, n_q[127]};
    diff = r2 - {1'b0, d_q};
    ge   = !diff[128];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd127);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 7'd127) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= num_i[127] ? 128'(-num_i) : num_i;
      d_q    <= den_i[127] ? 128'(-den_i) : den_i;
      neg_q  <= num_i[127] ^ den_i[127];
      zero_q <= (den_i == '0);
      r_q    <= '0;
      q_q    <= '0;
    end else if (busy_q) begin
      r_q <= ge ? diff[127:0] : r2[127:0];
      q_q <= {q_q[126:0], ge};
      n_q <= {n_q[126:0], 1'b0};
    end
  end

  always_comb begin
    if (zero_q) begin
      mag = '0;
    end else if (|q_q[127:62]) begin
      mag = T_LIMIT;
    end else begin
      mag = q_q[63:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? -$signed(mag) : $signed(mag);

endmodule

>>> hdl/cpts_back.sv
// ----------------------------------------------------------------------------
// cpts_back
// Solver sequencer: dot products, clamping and projections for one request
// at a time on a shared multiplier and divider.
// ----------------------------------------------------------------------------
module cpts_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        mode_i,
  input  logic [15:0]       eps_i,
  input  logic              item_valid_i,
  input  cpts_pkg::item_t   item_i,
  output logic              item_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output cpts_pkg::res_t    res_o
);
  import cpts_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam logic signed [127:0] HALF_W  = 128'sd1 <<< (F - 1);
  localparam logic signed [63:0]  ONE_Q   = 64'sd1 <<< F;
  localparam logic signed [127:0] I32_MIN = -128'sd2147483648;
  localparam logic signed [127:0] I32_MAX = 128'sd2147483647;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;

  function automatic logic signed [63:0] sx64(input logic [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  function automatic logic signed [127:0] sx128(input logic [63:0] v);
    return $signed({{64{v[63]}}, v});
  endfunction

  function automatic vec64_t wide3(input vec32_t v);
    vec64_t r;
    for (int i = 0; i < 3; i++) r[i] = sx64(v[i]);
    return r;
  endfunction

  function automatic logic degen(input logic signed [63:0] sq, input logic [15:0] eps);
    return (sq == 64'sd0) || (sq < $signed({48'd0, eps}));
  endfunction

  // {flag, t} after limiting t to the enabled ends of line B
  function automatic logic [67:0] clamp_b(input logic signed [63:0] t, input logic [3:0] m);
    logic [67:0] r;
    r = {4'd0, t};
    if (m[0] && t <= 64'sd0) begin
      r = {FLAG_LO_B, 64'd0};
    end else if (m[2] && t >= ONE_Q) begin
      r = {FLAG_HI_B, ONE_Q};
    end
    return r;
  endfunction

  state_e state_q, state_d, ret_q, ret_d, pj_ret_q, pj_ret_d;
  logic [1:0] idx_q, idx_d;

  item_t                  it_q, it_d;
  logic signed [63:0]     a_q, a_d, b_q, b_d, c_q, c_d, e_q, e_d, f_q, f_d;
  logic signed [127:0]    den_q, den_d, tmp_q, tmp_d, acc_q, acc_d, prod_q, prod_d;
  logic signed [63:0]     t1_q, t1_d, dot_q, dot_d, quo_q, quo_d, ptt_q, ptt_d;
  logic [3:0]             flags_q, flags_d, pj_mode_q, pj_mode_d, pj_r_q, pj_r_d;
  vec32_t                 cp0_q, cp0_d, cp1_q, cp1_d, ptb_q, ptb_d, ptv_q, ptv_d;
  vec32_t                 pto_q, pto_d, pj_p_q, pj_p_d, pj_b_q, pj_b_d, pj_v_q, pj_v_d;
  vec64_t                 du_q, du_d, dv_q, dv_d;
  logic signed [63:0]     ma_q, ma_d, mb_q, mb_d;
  logic signed [127:0]    dn_q, dn_d, dd_q, dd_d;

  // subroutine launch requests from the step logic
  logic                   call_dot, call_pt, call_mul, call_div, call_pj;
  vec64_t                 c_du, c_dv;
  vec32_t                 c_pb, c_pv, c_jp, c_jb, c_jv;
  logic signed [63:0]     c_pt, c_ma, c_mb;
  logic signed [127:0]    c_dn, c_dd;
  logic [3:0]             c_jm;
  state_e                 c_ret;

  logic                   mul_go, mul_done, div_go, div_done, start_ok;
  logic signed [63:0]     mul_a, mul_b, div_q;
  logic signed [127:0]    mul_p, acc_n, acc_sh, pt_sum, pt_w;
  logic [67:0]            cl;
  logic signed [63:0]     t0;
  logic [3:0]             fl;
  vec64_t                 g_w;

  assign start_ok = item_valid_i && !res_full_i;

  cpts_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  cpts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go),
    .num_i  (dn_q),
    .den_i  (dd_q),
    .done_o (div_done),
    .q_o    (div_q)
  );

  // next state and datapath
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  pj_ret_d = pj_ret_q;  idx_d = idx_q;
    it_d = it_q;  a_d = a_q;  b_d = b_q;  c_d = c_q;  e_d = e_q;  f_d = f_q;
    den_d = den_q;  tmp_d = tmp_q;  acc_d = acc_q;  prod_d = prod_q;
    t1_d = t1_q;  dot_d = dot_q;  quo_d = quo_q;  ptt_d = ptt_q;
    flags_d = flags_q;  pj_mode_d = pj_mode_q;  pj_r_d = pj_r_q;
    cp0_d = cp0_q;  cp1_d = cp1_q;  ptb_d = ptb_q;  ptv_d = ptv_q;  pto_d = pto_q;
    pj_p_d = pj_p_q;  pj_b_d = pj_b_q;  pj_v_d = pj_v_q;
    du_d = du_q;  dv_d = dv_q;  ma_d = ma_q;  mb_d = mb_q;  dn_d = dn_q;  dd_d = dd_q;

    call_dot = 1'b0;  call_pt = 1'b0;  call_mul = 1'b0;  call_div = 1'b0;
    call_pj = 1'b0;
    c_du = '0;  c_dv = '0;  c_pb = '0;  c_pv = '0;  c_pt = '0;  c_ma = '0;  c_mb = '0;
    c_dn = '0;  c_dd = '0;  c_jp = '0;  c_jb = '0;  c_jv = '0;  c_jm = '0;
    c_ret = ST_IDLE;

    acc_n  = acc_q + mul_p;
    acc_sh = acc_n >>> F;
    pt_sum = mul_p + HALF_W;
    pt_w   = (pt_sum >>> F) + sx128(sx64(ptb_q[idx_q]));
    cl     = clamp_b(quo_q, mode_i);
    t0     = quo_q;
    fl     = flags_q;
    for (int i = 0; i < 3; i++) begin
      g_w[i] = 64'($signed({pto_q[i][31], pto_q[i]}) - $signed({it_q.p1[i][31], it_q.p1[i]}));
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_ok) begin
          it_d     = item_i;
          call_dot = 1'b1;
          c_du     = wide3(item_i.v0);
          c_dv     = wide3(item_i.v0);
          c_ret    = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        a_d = dot_q;
        if (degen(dot_q, eps_i)) begin
          cp0_d   = it_q.p0;
          call_pj = 1'b1;
          c_jp = it_q.p0;  c_jb = it_q.p1;  c_jv = it_q.v1;  c_jm = mode_i;
          c_ret   = ST_DEG_END;
        end else begin
          call_dot = 1'b1;
          c_du = wide3(it_q.v0);  c_dv = wide3(it_q.v1);  c_ret = ST_GOT_B;
        end
      end
      ST_GOT_B: begin
        b_d = dot_q;
        call_dot = 1'b1;
        c_du = wide3(it_q.v1);  c_dv = wide3(it_q.v1);  c_ret = ST_GOT_C;
      end
      ST_GOT_C: begin
        c_d = dot_q;
        call_dot = 1'b1;
        c_du = wide3(it_q.v0);
        for (int i = 0; i < 3; i++) c_dv[i] = {{31{it_q.d[i][32]}}, it_q.d[i]};
        c_ret = ST_GOT_E;
      end
      ST_GOT_E: begin
        e_d = dot_q;
        call_dot = 1'b1;
        c_du = wide3(it_q.v1);
        for (int i = 0; i < 3; i++) c_dv[i] = {{31{it_q.d[i][32]}}, it_q.d[i]};
        c_ret = ST_GOT_F;
      end
      ST_GOT_F: begin
        f_d = dot_q;
        call_mul = 1'b1;  c_ma = a_q;  c_mb = c_q;  c_ret = ST_AC;
      end
      ST_AC: begin
        tmp_d = prod_q;
        call_mul = 1'b1;  c_ma = b_q;  c_mb = b_q;  c_ret = ST_BB;
      end
      ST_BB: begin
        den_d = tmp_q - prod_q;
        call_mul = 1'b1;  c_ma = $signed({48'd0, eps_i});  c_mb = a_q;  c_ret = ST_EA;
      end
      ST_EA: begin
        if (den_q <= 128'sd0 || den_q < prod_q) begin
          // near-parallel: two point-to-line projections
          call_pj = 1'b1;
          c_jp = it_q.p0;  c_jb = it_q.p1;  c_jv = it_q.v1;  c_jm = mode_i;
          c_ret = ST_PAR1;
        end else begin
          call_mul = 1'b1;  c_ma = a_q;  c_mb = f_q;  c_ret = ST_AF;
        end
      end
      ST_AF: begin
        tmp_d = prod_q;
        call_mul = 1'b1;  c_ma = b_q;  c_mb = e_q;  c_ret = ST_BE;
      end
      ST_BE: begin
        call_div = 1'b1;
        c_dn = (tmp_q - prod_q) <<< F;  c_dd = den_q;  c_ret = ST_T1;
      end
      ST_T1: begin
        t1_d    = $signed(cl[63:0]);
        flags_d = cl[67:64];
        call_mul = 1'b1;  c_ma = b_q;  c_mb = $signed(cl[63:0]);  c_ret = ST_BT;
      end
      ST_BT: begin
        call_div = 1'b1;
        c_dn = prod_q - (sx128(e_q) <<< F);  c_dd = sx128(a_q);  c_ret = ST_T0;
      end
      ST_T0: begin
        if (mode_i[3] && quo_q >= ONE_Q) begin
          t0 = ONE_Q;  fl = flags_q | FLAG_HI_A;
        end else if (mode_i[1] && quo_q <= 64'sd0) begin
          t0 = 64'sd0;  fl = flags_q | FLAG_LO_A;
        end
        flags_d = fl;
        call_pt = 1'b1;
        c_pb = it_q.p0;  c_pv = it_q.v0;  c_pt = t0;  c_ret = ST_CP0;
      end
      ST_CP0: begin
        cp0_d = pto_q;
        if ((flags_q & FLAGS_A) != 4'd0) begin
          // an end of A was hit: redo t1 from the clamped point on A
          call_dot = 1'b1;
          c_du = wide3(it_q.v1);  c_dv = g_w;  c_ret = ST_G;
        end else begin
          call_pt = 1'b1;
          c_pb = it_q.p1;  c_pv = it_q.v1;  c_pt = t1_q;  c_ret = ST_CP1;
        end
      end
      ST_G: begin
        if (c_q == 64'sd0) begin
          cl      = clamp_b(64'sd0, mode_i);
          t1_d    = $signed(cl[63:0]);
          flags_d = (flags_q & FLAGS_A) | cl[67:64];
          call_pt = 1'b1;
          c_pb = it_q.p1;  c_pv = it_q.v1;  c_pt = $signed(cl[63:0]);  c_ret = ST_CP1;
        end else begin
          call_div = 1'b1;
          c_dn = sx128(dot_q) <<< F;  c_dd = sx128(c_q);  c_ret = ST_RC;
        end
      end
      ST_RC: begin
        t1_d    = $signed(cl[63:0]);
        flags_d = (flags_q & FLAGS_A) | cl[67:64];
        call_pt = 1'b1;
        c_pb = it_q.p1;  c_pv = it_q.v1;  c_pt = $signed(cl[63:0]);  c_ret = ST_CP1;
      end
      ST_CP1: begin
        cp1_d   = pto_q;
        state_d = ST_DONE;
      end
      ST_PAR1: begin
        cp1_d   = pto_q;
        flags_d = pj_r_q;
        call_pj = 1'b1;
        c_jp = pto_q;  c_jb = it_q.p0;  c_jv = it_q.v0;  c_jm = {1'b0, mode_i[3:1]};
        c_ret = ST_PAR2;
      end
      ST_PAR2: begin
        cp0_d   = pto_q;
        flags_d = (flags_q | {pj_r_q[2:0], 1'b0}) & FLAGS_ALL;
        state_d = ST_DONE;
      end
      ST_DEG_END: begin
        cp1_d   = pto_q;
        flags_d = FLAGS_A | pj_r_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      // dot product of du and dv, one term per multiply
      ST_DOT: begin
        state_d = ST_DOT_W;
      end
      ST_DOT_W: begin
        if (mul_done) begin
          acc_d = acc_n;
          if (idx_q == 2'd2) begin
            dot_d   = acc_sh[63:0];
            state_d = ret_q;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_DOT;
          end
        end
      end
      // point on a line: base + dir * t, rounded and saturated
      ST_PT: begin
        state_d = ST_PT_W;
      end
      ST_PT_W: begin
        if (mul_done) begin
          if (pt_w < I32_MIN) begin
            pto_d[idx_q] = 32'h8000_0000;
          end else if (pt_w > I32_MAX) begin
            pto_d[idx_q] = 32'h7FFF_FFFF;
          end else begin
            pto_d[idx_q] = pt_w[31:0];
          end
          if (idx_q == 2'd2) begin
            state_d = ret_q;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_PT;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_MUL_W;
      end
      ST_MUL_W: begin
        if (mul_done) begin
          prod_d  = mul_p;
          state_d = ret_q;
        end
      end
      ST_DIV: begin
        state_d = ST_DIV_W;
      end
      ST_DIV_W: begin
        if (div_done) begin
          quo_d   = div_q;
          state_d = ret_q;
        end
      end
      // projection of pj_p onto the line pj_b + t * pj_v
      ST_PJ_START: begin
        call_dot = 1'b1;
        c_du = wide3(pj_v_q);  c_dv = wide3(pj_v_q);  c_ret = ST_PJ_C;
      end
      ST_PJ_C: begin
        tmp_d = sx128(dot_q);
        if (degen(dot_q, eps_i)) begin
          pto_d   = pj_b_q;
          pj_r_d  = FLAGS_ALL;
          state_d = pj_ret_q;
        end else begin
          call_dot = 1'b1;
          c_du = wide3(pj_v_q);
          for (int i = 0; i < 3; i++) begin
            c_dv[i] = 64'($signed({pj_p_q[i][31], pj_p_q[i]})
                        - $signed({pj_b_q[i][31], pj_b_q[i]}));
          end
          c_ret = ST_PJ_DD;
        end
      end
      ST_PJ_DD: begin
        call_div = 1'b1;
        c_dn = sx128(dot_q) <<< F;  c_dd = tmp_q;  c_ret = ST_PJ_T;
      end
      ST_PJ_T: begin
        t0 = quo_q;
        fl = 4'd0;
        if (pj_mode_q[0] && quo_q < 64'sd0) begin
          t0 = 64'sd0;  fl = FLAG_LO_B;
        end else if (pj_mode_q[2] && quo_q > ONE_Q) begin
          t0 = ONE_Q;  fl = FLAG_HI_B;
        end
        pj_r_d  = fl;
        call_pt = 1'b1;
        c_pb = pj_b_q;  c_pv = pj_v_q;  c_pt = t0;  c_ret = pj_ret_q;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // launch the requested subroutine
    if (call_dot) begin
      du_d = c_du;  dv_d = c_dv;  idx_d = '0;  acc_d = HALF_W;
      ret_d = c_ret;  state_d = ST_DOT;
    end
    if (call_pt) begin
      ptb_d = c_pb;  ptv_d = c_pv;  ptt_d = c_pt;  idx_d = '0;
      ret_d = c_ret;  state_d = ST_PT;
    end
    if (call_mul) begin
      ma_d = c_ma;  mb_d = c_mb;  ret_d = c_ret;  state_d = ST_MUL;
    end
    if (call_div) begin
      dn_d = c_dn;  dd_d = c_dd;  ret_d = c_ret;  state_d = ST_DIV;
    end
    if (call_pj) begin
      pj_p_d = c_jp;  pj_b_d = c_jb;  pj_v_d = c_jv;  pj_mode_d = c_jm;
      pj_ret_d = c_ret;  state_d = ST_PJ_START;
    end
  end

  // outputs
  always_comb begin
    mul_go     = 1'b0;
    mul_a      = ma_q;
    mul_b      = mb_q;
    div_go     = 1'b0;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE: item_pop_o = start_ok;
      ST_DOT: begin
        mul_go = 1'b1;
        mul_a  = $signed(du_q[idx_q]);
        mul_b  = $signed(dv_q[idx_q]);
      end
      ST_PT: begin
        mul_go = 1'b1;
        mul_a  = sx64(ptv_q[idx_q]);
        mul_b  = ptt_q;
      end
      ST_MUL:  mul_go = 1'b1;
      ST_DIV:  div_go = 1'b1;
      ST_DONE: res_push_o = 1'b1;
      default: mul_go = 1'b0;
    endcase
  end

  assign res_o.cp0   = cp0_q;
  assign res_o.cp1   = cp1_q;
  assign res_o.flags = flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      pj_ret_q <= ST_IDLE;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      pj_ret_q <= pj_ret_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;  a_q <= a_d;  b_q <= b_d;  c_q <= c_d;  e_q <= e_d;  f_q <= f_d;
    den_q <= den_d;  tmp_q <= tmp_d;  acc_q <= acc_d;  prod_q <= prod_d;
    t1_q <= t1_d;  dot_q <= dot_d;  quo_q <= quo_d;  ptt_q <= ptt_d;
    flags_q <= flags_d;  pj_mode_q <= pj_mode_d;  pj_r_q <= pj_r_d;
    cp0_q <= cp0_d;  cp1_q <= cp1_d;  ptb_q <= ptb_d;  ptv_q <= ptv_d;  pto_q <= pto_d;
    pj_p_q <= pj_p_d;  pj_b_q <= pj_b_d;  pj_v_q <= pj_v_d;
    du_q <= du_d;  dv_q <= dv_d;  ma_q <= ma_d;  mb_q <= mb_d;  dn_q <= dn_d;  dd_q <= dd_d;
  end

endmodule

>>> hdl/closest_points_two_segments_unit.sv
// The shared divider computes up to three quotients per request.
// Requests are solved one at a time; the intake queue takes a request every
//   cycle until it fills.
// Reset (rst_ni low, asynchronous): queues empty, sequencer idle,
//   clamp_mode = 15, epsilon_sq = 1. No clearing pass.
// ----------------------------------------------------------------------------
// closest_points_two_segments_unit
// Closest points between two 3D lines or segments in signed fixed point.
// ----------------------------------------------------------------------------
module closest_points_two_segments_unit #(
  parameter int FRACTION_BITS = 16,
  parameter int QUEUE_DEPTH   = 4,
  parameter int RESULT_DEPTH  = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request side
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] start_a_x_i,
  input  logic signed [31:0] start_a_y_i,
  input  logic signed [31:0] start_a_z_i,
  input  logic signed [31:0] dir_a_x_i,
  input  logic signed [31:0] dir_a_y_i,
  input  logic signed [31:0] dir_a_z_i,
  input  logic signed [31:0] start_b_x_i,
  input  logic signed [31:0] start_b_y_i,
  input  logic signed [31:0] start_b_z_i,
  input  logic signed [31:0] dir_b_x_i,
  input  logic signed [31:0] dir_b_y_i,
  input  logic signed [31:0] dir_b_z_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] nearest_a_x_o,
  output logic signed [31:0] nearest_a_y_o,
  output logic signed [31:0] nearest_a_z_o,
  output logic signed [31:0] nearest_b_x_o,
  output logic signed [31:0] nearest_b_y_o,
  output logic signed [31:0] nearest_b_z_o,
  output logic [3:0]         clamp_flags_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cpts_pkg::*;

  logic [3:0]  clamp_mode_q;
  logic [15:0] epsilon_sq_q;
  logic        cfg_wr;

  logic        item_valid, item_pop, res_push, res_full;
  item_t       item;
  res_t        res_in, res_out;
  logic [$bits(res_t)-1:0] res_bits;

  // Configuration: write on the access phase, register index in paddr[2].
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_mode_q <= CLAMP_MODE_RST;
      epsilon_sq_q <= EPSILON_SQ_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CLAMP_MODE: clamp_mode_q <= pwdata[3:0];
        REG_EPSILON_SQ: epsilon_sq_q <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CLAMP_MODE: prdata = {28'd0, clamp_mode_q};
      REG_EPSILON_SQ: prdata = {16'd0, epsilon_sq_q};
    endcase
  end

  // Front: take requests into the intake queue.
  cpts_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .p0_i   ({start_a_z_i, start_a_y_i, start_a_x_i}),
    .v0_i   ({dir_a_z_i, dir_a_y_i, dir_a_x_i}),
    .p1_i   ({start_b_z_i, start_b_y_i, start_b_x_i}),
    .v1_i   ({dir_b_z_i, dir_b_y_i, dir_b_x_i}),
    .pop_i  (item_pop),
    .valid_o(item_valid),
    .item_o (item)
  );

  // Back: solve one request at a time; start one only when a result slot is free.
  cpts_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (clamp_mode_q),
    .eps_i       (epsilon_sq_q),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue: hold finished results until popped.
  cpts_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_bits),
    .empty_o(empty)
  );

  assign res_out       = res_t'(res_bits);
  assign nearest_a_x_o = $signed(res_out.cp0[0]);
  assign nearest_a_y_o = $signed(res_out.cp0[1]);
  assign nearest_a_z_o = $signed(res_out.cp0[2]);
  assign nearest_b_x_o = $signed(res_out.cp1[0]);
  assign nearest_b_y_o = $signed(res_out.cp1[1]);
  assign nearest_b_z_o = $signed(res_out.cp1[2]);
  assign clamp_flags_o = res_out.flags;

endmodule

>>> hdl/cpts_checker.sv
// ----------------------------------------------------------------------------
// cpts_checker
// Port-level checks for the closest-points unit, bound to the top level.
// ----------------------------------------------------------------------------
module cpts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] nearest_a_x_o,
  input logic [3:0]  clamp_flags_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // queues come out of reset empty
  assert property (@(posedge clk_i) $rose(rst_ni) |-> empty && !full)
    else $error("queues not empty after reset");

  // clamp_mode reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 !paddr[2]
      |-> prdata == {28'd0, $past(pwdata[3:0])})
    else $error("clamp_mode readback mismatch");

  // epsilon_sq reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[2]) ##1 paddr[2]
      |-> prdata == {16'd0, $past(pwdata[15:0])})
    else $error("epsilon_sq readback mismatch");

  // a waiting result holds until it is popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(nearest_a_x_o) && $stable(clamp_flags_o))
    else $error("waiting result changed");

endmodule

bind closest_points_two_segments_unit cpts_checker u_cpts_checker (.*);
